// ----- rtl/wbps_pkg.sv -----
// Shared types and constants for the wildcard byte pattern search block.
package wbps_pkg;

    localparam int DATA_W    = 8;
    localparam int INDEX_W   = 5;
    localparam int PLEN_W    = 6;
    localparam int OFFSET_W  = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [1:0] REG_USE_WILDCARD   = 2'd1;
    localparam logic [1:0] REG_WILDCARD_BYTE  = 2'd2;

    // Input opcodes
    localparam logic OP_PATTERN  = 1'b0;
    localparam logic OP_HAYSTACK = 1'b1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic               opcode;
        logic [DATA_W-1:0]  data_byte;
        logic [INDEX_W-1:0] pattern_index;
        logic               last_byte;
    } item_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
    } result_t;

    typedef enum logic {
        KIND_PATTERN  = 1'b0,
        KIND_HAYSTACK = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
    } queue_entry_t;

    typedef struct packed {
        logic [PLEN_W-1:0] pattern_length;
        logic              use_wildcard;
        logic [DATA_W-1:0] wildcard_byte;
    } cfg_t;

endpackage

// ----- rtl/wildcard_byte_pattern_search.sv -----
// Top level of the wildcard byte pattern search block.
// Finds the first occurrence of a stored byte pattern in a streamed haystack.
// Each input beat either writes one pattern byte (opcode 0, by pattern_index)
// or presents one haystack byte (opcode 1); last_byte closes a search. The
// block takes one beat per cycle while the queue is not full: the front end
// classifies each beat and pushes it into a four-entry queue, and the search
// engine drains one entry per cycle unless a haystack byte waits on a held
// result, shifting haystack bytes into a window that is compared with the
// whole pattern in parallel; result_valid is registered as the engine pops the
// deciding byte. While a result waits to be taken, the engine holds the next
// haystack byte at the head of the queue (pattern writes still drain), and the
// queue keeps taking beats until its four entries are full; a result taken in
// the same cycle lets the next haystack byte advance at once. A search reports
// at most one result: found=1 with the start offset at the first match, or
// found=0 on the last byte when nothing matched. The offset counter saturates
// at its maximum. Write configuration registers (pattern_length at 0x0,
// use_wildcard at 0x4, wildcard_byte at 0x8) only while the block is idle.
module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_ready,
    input  wbps_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_ready,
    output wbps_pkg::result_t                result,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import wbps_pkg::*;

    cfg_t         cfg;
    logic         push;
    queue_entry_t push_entry;
    logic         queue_full;
    logic         head_valid;
    queue_entry_t head;
    logic         pop;

    // Hold the register set that the engine reads on every compare
    wbps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept beats and drop pattern writes outside the store
    wbps_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Buffer classified beats so either side can stall alone
    wbps_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Advance the window, compare, and register the result beat
    wbps_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ----- rtl/wbps_cfg.sv -----
// Configuration registers behind the APB-style port.
module wbps_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output wbps_pkg::cfg_t                   cfg
);
    import wbps_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign wr_en     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_PATTERN_LENGTH: cfg_reg.pattern_length <= pwdata[PLEN_W-1:0];
                REG_USE_WILDCARD:   cfg_reg.use_wildcard   <= pwdata[0];
                REG_WILDCARD_BYTE:  cfg_reg.wildcard_byte  <= pwdata[DATA_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_PATTERN_LENGTH: prdata = APB_DATA_W'(cfg_reg.pattern_length);
            REG_USE_WILDCARD:   prdata = APB_DATA_W'(cfg_reg.use_wildcard);
            REG_WILDCARD_BYTE:  prdata = APB_DATA_W'(cfg_reg.wildcard_byte);
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/wbps_front.sv -----
// Front end: accept input beats, classify them and push them into the queue.
module wbps_front #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                   item_valid,
    output logic                   item_ready,
    input  wbps_pkg::item_t        item,
    input  logic                   queue_full,
    output logic                   push,
    output wbps_pkg::queue_entry_t push_entry
);
    import wbps_pkg::*;

    logic accept;
    logic index_ok;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;
    // Drop pattern writes beyond the store; they have no effect at all.
    assign index_ok   = 32'(item.pattern_index) < MAX_PATTERN;

    always_comb
    begin
        push_entry.data  = item.data_byte;
        push_entry.index = item.pattern_index;
        if (item.opcode == OP_HAYSTACK)
        begin
            push_entry.kind = KIND_HAYSTACK;
            push_entry.last = item.last_byte;
            push            = accept;
        end
        else
        begin
            push_entry.kind = KIND_PATTERN;
            push_entry.last = 1'b0;
            push            = accept && index_ok;
        end
    end

endmodule

// ----- rtl/wbps_queue.sv -----
// Short queue that decouples the front end from the search engine.
module wbps_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  wbps_pkg::queue_entry_t push_entry,
    output logic                   full,
    output logic                   head_valid,
    output wbps_pkg::queue_entry_t head,
    input  logic                   pop
);
    import wbps_pkg::*;

    localparam logic [QCNT_W-1:0] COUNT_FULL = QCNT_W'(QUEUE_DEPTH);

    queue_entry_t      entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = count_reg == COUNT_FULL;
    assign head_valid = count_reg != '0;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/wbps_back.sv -----
// Search engine: pattern store, byte window, parallel compare and result register.
module wbps_back #(
    parameter int MAX_PATTERN = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  wbps_pkg::cfg_t         cfg,
    input  logic                   head_valid,
    input  wbps_pkg::queue_entry_t head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output wbps_pkg::result_t      result
);
    import wbps_pkg::*;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [DATA_W-1:0]   pattern_reg [MAX_PATTERN];
    logic [DATA_W-1:0]   window_reg  [MAX_PATTERN];
    logic [OFFSET_W-1:0] seen_reg;
    logic [OFFSET_W-1:0] seen_next;
    logic                reported_reg;
    logic                result_valid_reg;
    result_t             result_reg;

    logic [PLEN_W-1:0]      act_len;
    logic [DATA_W-1:0]      shift_win [MAX_PATTERN];
    logic [IDX_W-1:0]       pos_idx   [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] pos_ok;
    logic                   hay_pop;
    logic                   matched;
    logic                   emit_found;
    logic                   emit_miss;

    // Pattern writes never need the output slot; haystack bytes wait for it.
    assign pop = head_valid &&
                 (head.kind == KIND_PATTERN || !result_valid_reg || result_ready);
    assign hay_pop = pop && head.kind == KIND_HAYSTACK;

    assign act_len = (32'(cfg.pattern_length) > MAX_PATTERN) ?
                     PLEN_W'(MAX_PATTERN) : cfg.pattern_length;

    assign seen_next = (seen_reg == '1) ? seen_reg : seen_reg + OFFSET_W'(1);

    // Window as it stands once the head byte has shifted in; entry 0 is newest.
    always_comb
    begin
        shift_win[0] = head.data;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            shift_win[k] = window_reg[k-1];
        end
    end

    // Pattern byte i lines up with the byte seen act_len-1-i haystack bytes ago.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos_idx[i] = '0;
            if (32'(i) < 32'(act_len))
            begin
                pos_idx[i] = IDX_W'(32'(act_len) - 32'(i) - 32'd1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos_ok[i] = (32'(i) >= 32'(act_len)) ||
                        (cfg.use_wildcard && pattern_reg[i] == cfg.wildcard_byte) ||
                        (pattern_reg[i] == shift_win[pos_idx[i]]);
        end
    end

    assign matched    = (&pos_ok) && (seen_next >= OFFSET_W'(act_len));
    assign emit_found = hay_pop && !reported_reg && matched;
    assign emit_miss  = hay_pop && !reported_reg && !matched && head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= '0;
            reported_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (hay_pop)
            begin
                if (head.last)
                begin
                    seen_reg     <= '0;
                    reported_reg <= 1'b0;
                end
                else
                begin
                    seen_reg <= seen_next;
                    if (emit_found)
                    begin
                        reported_reg <= 1'b1;
                    end
                end
            end
            if (emit_found || emit_miss)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Window needs no clear: only bytes shifted in since the search began are compared.
    always_ff @(posedge clk)
    begin
        if (hay_pop)
        begin
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                window_reg[k] <= shift_win[k];
            end
        end
        if (pop && head.kind == KIND_PATTERN)
        begin
            pattern_reg[IDX_W'(head.index)] <= head.data;
        end
        if (emit_found)
        begin
            result_reg.found        <= 1'b1;
            result_reg.match_offset <= (act_len == '0) ? '0 :
                                       seen_next - OFFSET_W'(act_len);
        end
        else if (emit_miss)
        begin
            result_reg.found        <= 1'b0;
            result_reg.match_offset <= '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
